[hw/rtl/bcd_calendar_day_advance_top_defines.svh]
// Assertion macros for the packed-BCD next-day block.
// Included by the top level; no other dependencies.
`ifndef BCD_CALENDAR_DAY_ADVANCE_TOP_DEFINES_SVH
`define BCD_CALENDAR_DAY_ADVANCE_TOP_DEFINES_SVH

// check a condition that must hold in the same cycle
`define BCDCA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcdca: same-cycle check failed");

// check a condition that must hold in the next cycle
`define BCDCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcdca: next-cycle check failed");

`endif

[hw/rtl/bcdca_pkg.sv]
// Shared types, constants and BCD helpers for the next-day pipeline.
// No dependencies.
package bcdca_pkg;

   localparam logic [4:0] MONTH_FEB = 5'h02;
   localparam logic [4:0] MONTH_APR = 5'h04;
   localparam logic [4:0] MONTH_JUN = 5'h06;
   localparam logic [4:0] MONTH_SEP = 5'h09;
   localparam logic [4:0] MONTH_NOV = 5'h11;

   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;

   localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
   localparam logic [7:0] YEAR_LAST      = 8'd99;
   localparam logic [7:0] CENTURY_SPAN   = 8'd100;

   typedef struct packed {
      logic [15:0] year_bcd;
      logic [4:0]  month_bcd;
      logic [5:0]  day_bcd;
   } date_type;

   typedef struct packed {
      date_type    date;
      logic [5:0]  day_val;
      logic [4:0]  month_val;
      logic [7:0]  cen_val;
      logic [7:0]  yy_val;
   } dec_type;

   typedef struct packed {
      logic [15:0] year_bcd;
      logic [4:0]  month_bcd;
      logic        day_wrap;
      logic [5:0]  inc_day;
      logic        month_wrap;
      logic [4:0]  inc_month;
      logic        yy_wrap;
      logic [15:0] inc_year;
      logic        cen_wrap;
      logic [7:0]  inc_cen;
   } cand_type;

   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0, b[7:4]};
      lo = {4'b0, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   // v stays at or below 99 wherever the result is used
   function automatic logic [7:0] bcd_encode(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] ones;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      ones = v - 7'(tens * 10);
      return {tens, ones[3:0]};
   endfunction

endpackage

[hw/rtl/bcdca_decode.sv]
// Stage one: decode the BCD day, month, century and year bytes to binary.
// Depends on bcdca_pkg.
module bcdca_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 src_valid,
   output logic                 src_ready,
   input  bcdca_pkg::date_type  src_data,
   output logic                 dst_valid,
   input  logic                 dst_ready,
   output bcdca_pkg::dec_type   dst_data
);

   logic               valid_ff;
   bcdca_pkg::dec_type data_ff;
   bcdca_pkg::dec_type data_in;
   logic [7:0]         day_dec;
   logic [7:0]         month_dec;

   assign src_ready = !valid_ff || dst_ready;
   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

   always_comb begin
      day_dec           = bcdca_pkg::bcd_decode({2'b0, src_data.day_bcd});
      month_dec         = bcdca_pkg::bcd_decode({3'b0, src_data.month_bcd});
      data_in.date      = src_data;
      data_in.day_val   = day_dec[5:0];
      data_in.month_val = month_dec[4:0];
      data_in.cen_val   = bcdca_pkg::bcd_decode(src_data.year_bcd[15:8]);
      data_in.yy_val    = bcdca_pkg::bcd_decode(src_data.year_bcd[7:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/bcdca_limit.sv]
// Stage two: month length with leap test, rollover flags and incremented fields.
// Depends on bcdca_pkg.
module bcdca_limit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 src_valid,
   output logic                 src_ready,
   input  bcdca_pkg::dec_type   src_data,
   output logic                 dst_valid,
   input  logic                 dst_ready,
   output bcdca_pkg::cand_type  dst_data
);

   logic                valid_ff;
   bcdca_pkg::cand_type data_ff;
   bcdca_pkg::cand_type data_in;
   logic [4:0]          limit;
   logic                yy_over;
   logic [7:0]          yy_rem;
   logic [7:0]          cen_adj;
   logic                leap;
   logic [7:0]          day_enc;
   logic [7:0]          month_enc;
   logic [7:0]          yy_enc;

   assign src_ready = !valid_ff || dst_ready;
   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

   // year may decode past 99; fold the excess hundred into the century
   always_comb begin
      yy_over = src_data.yy_val >= bcdca_pkg::CENTURY_SPAN;
      yy_rem  = yy_over ? src_data.yy_val - bcdca_pkg::CENTURY_SPAN : src_data.yy_val;
      cen_adj = src_data.cen_val + {7'b0, yy_over};
      leap    = (yy_rem[1:0] == 2'b00) && ((yy_rem != 8'd0) || (cen_adj[1:0] == 2'b00));
   end

   always_comb begin
      priority if (src_data.date.month_bcd == bcdca_pkg::MONTH_APR ||
                   src_data.date.month_bcd == bcdca_pkg::MONTH_JUN ||
                   src_data.date.month_bcd == bcdca_pkg::MONTH_SEP ||
                   src_data.date.month_bcd == bcdca_pkg::MONTH_NOV) begin
         limit = bcdca_pkg::DAYS_SHORT;
      end else if (src_data.date.month_bcd == bcdca_pkg::MONTH_FEB) begin
         limit = leap ? bcdca_pkg::DAYS_LEAP : bcdca_pkg::DAYS_FEB;
      end else begin
         limit = bcdca_pkg::DAYS_LONG;
      end
   end

   always_comb begin
      day_enc   = bcdca_pkg::bcd_encode({1'b0, src_data.day_val} + 7'd1);
      month_enc = bcdca_pkg::bcd_encode({2'b0, src_data.month_val} + 7'd1);
      yy_enc    = bcdca_pkg::bcd_encode(src_data.yy_val[6:0] + 7'd1);

      data_in.year_bcd   = src_data.date.year_bcd;
      data_in.month_bcd  = src_data.date.month_bcd;
      data_in.day_wrap   = src_data.day_val >= {1'b0, limit};
      data_in.inc_day    = day_enc[5:0];
      data_in.month_wrap = src_data.month_val >= bcdca_pkg::MONTHS_PER_YEAR;
      data_in.inc_month  = month_enc[4:0];
      data_in.yy_wrap    = src_data.yy_val >= bcdca_pkg::YEAR_LAST;
      data_in.inc_year   = {src_data.date.year_bcd[15:8], yy_enc};
      data_in.cen_wrap   = src_data.cen_val >= bcdca_pkg::YEAR_LAST;
      data_in.inc_cen    = bcdca_pkg::bcd_encode(src_data.cen_val[6:0] + 7'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/bcdca_select.sv]
// Stage three: pick the next date from the rollover flags into the output register.
// Depends on bcdca_pkg.
module bcdca_select (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 src_valid,
   output logic                 src_ready,
   input  bcdca_pkg::cand_type  src_data,
   output logic                 dst_valid,
   input  logic                 dst_ready,
   output bcdca_pkg::date_type  dst_data
);

   logic                valid_ff;
   bcdca_pkg::date_type data_ff;
   bcdca_pkg::date_type data_in;

   assign src_ready = !valid_ff || dst_ready;
   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

   always_comb begin
      data_in.day_bcd   = src_data.day_wrap ? 6'h01 : src_data.inc_day;
      data_in.month_bcd = src_data.month_bcd;
      data_in.year_bcd  = src_data.year_bcd;
      if (src_data.day_wrap) begin
         data_in.month_bcd = src_data.month_wrap ? 5'h01 : src_data.inc_month;
         if (src_data.month_wrap) begin
            priority if (!src_data.yy_wrap) begin
               data_in.year_bcd = src_data.inc_year;
            end else if (!src_data.cen_wrap) begin
               data_in.year_bcd = {src_data.inc_cen, 8'h00};
            end else begin
               data_in.year_bcd = 16'h0000;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/bcd_calendar_day_advance_top.sv]
// Packed-BCD next-day calculator: a date in, the following date out.
// Usage:
//   req_* carries one date per transfer; rsp_* returns the following date.
//   Both sides are tvalid/tready streams; a transfer happens when both are high.
//   tdata fields from bit 0 up: day (6 bits), month (5 bits), year (16 bits),
//   upper five bits zero.
// Path: a request transfer reaches rsp_tvalid through the decode, month-limit and
//   select register stages. Throughput: one date per cycle while not stalled;
//   each stage holds one date with its own valid.
// Stall: when rsp_tready is low the output register holds its date and the
//   stages behind it keep filling bubbles; once all three are full req_tready
//   drops. Nothing is dropped or repeated.
// Reset: synchronous, active high; clears every stage valid, so rsp_tvalid is
//   low and req_tready is high in the cycle after reset.
// Depends on bcdca_pkg, bcdca_decode, bcdca_limit, bcdca_select and the
//   assertion macro header.
`include "bcd_calendar_day_advance_top_defines.svh"

module bcd_calendar_day_advance_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // day_bcd[5:0], month_bcd[10:6], year_bcd[26:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // next_day_bcd[5:0], next_month_bcd[10:6],
                                    // next_year_bcd[26:11]
);

   bcdca_pkg::date_type req_date;
   bcdca_pkg::date_type rsp_date;
   bcdca_pkg::dec_type  dec_data;
   bcdca_pkg::cand_type cand_data;
   logic                dec_valid;
   logic                dec_ready;
   logic                cand_valid;
   logic                cand_ready;

   always_comb begin
      req_date.day_bcd   = req_tdata[5:0];
      req_date.month_bcd = req_tdata[10:6];
      req_date.year_bcd  = req_tdata[26:11];
   end

   assign rsp_tdata = {5'b0, rsp_date.year_bcd, rsp_date.month_bcd, rsp_date.day_bcd};

   bcdca_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .src_valid (req_tvalid),
      .src_ready (req_tready),
      .src_data  (req_date),
      .dst_valid (dec_valid),
      .dst_ready (dec_ready),
      .dst_data  (dec_data)
   );

   bcdca_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .src_valid (dec_valid),
      .src_ready (dec_ready),
      .src_data  (dec_data),
      .dst_valid (cand_valid),
      .dst_ready (cand_ready),
      .dst_data  (cand_data)
   );

   bcdca_select u_select (
      .clock     (clock),
      .reset     (reset),
      .src_valid (cand_valid),
      .src_ready (cand_ready),
      .src_data  (cand_data),
      .dst_valid (rsp_tvalid),
      .dst_ready (rsp_tready),
      .dst_data  (rsp_date)
   );

   `BCDCA_ASSERT_NOW(a_day_is_bcd, clock, reset, rsp_tvalid, rsp_tdata[5:0] != 6'h00 && rsp_tdata[3:0] <= 4'd9)
   `BCDCA_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BCDCA_ASSERT_NOW(a_full_blocks_input, clock, reset, rsp_tvalid && !rsp_tready && dec_valid && cand_valid, !req_tready)
   `BCDCA_ASSERT_NEXT(a_transfer_enters, clock, reset, req_tvalid && req_tready, dec_valid)

endmodule

[bench/bcd_calendar_day_advance_top_test.sv]
// Stream test of bcd_calendar_day_advance_top: packed-BCD dates in, next-day dates out,
// each result checked against a next-day calculation kept in this file.
// Depends on bcdca_pkg and the block's RTL.
module bcd_calendar_day_advance_top_test;

   localparam int HOLD_CYCLES = 60;

   typedef struct {
      logic [5:0]  day;
      logic [4:0]  month;
      logic [15:0] year;
      int          send_idle_pct;
      int          recv_idle_pct;
      bit          wait_drained;
      bit          hold_rsp;
   } date_req_type;

   typedef struct {
      logic [5:0]  day;
      logic [4:0]  month;
      logic [15:0] year;
   } next_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   date_req_type  pending_dates[$];
   next_date_type expected_dates[$];
   int            mismatches = 0;
   int            recv_idle_pct = 0;
   int            hold_requests = 0;
   int            holds_done = 0;
   int            hold_left = 0;
   int            phase_send_pct = 0;
   int            phase_recv_pct = 0;
   bit            mark_wait_drained = 1'b0;
   bit            mark_hold_rsp = 1'b0;

   bcd_calendar_day_advance_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int digits_value(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic next_date_type following_date(logic [5:0] day, logic [4:0] month,
                                                    logic [15:0] year);
      int            day_num;
      int            month_num;
      int            cen_num;
      int            yy_num;
      int            full_year;
      int            month_len;
      logic [7:0]    enc;
      next_date_type nd;
      day_num   = digits_value({2'b00, day});
      month_num = digits_value({3'b000, month});
      cen_num   = digits_value(year[15:8]);
      yy_num    = digits_value(year[7:0]);
      full_year = cen_num * 100 + yy_num;
      nd.day    = day;
      nd.month  = month;
      nd.year   = year;
      if (month == bcdca_pkg::MONTH_APR || month == bcdca_pkg::MONTH_JUN ||
          month == bcdca_pkg::MONTH_SEP || month == bcdca_pkg::MONTH_NOV)
         month_len = int'(bcdca_pkg::DAYS_SHORT);
      else if (month == bcdca_pkg::MONTH_FEB)
         month_len = (full_year % 4 == 0 && (full_year % 100 != 0 || full_year % 400 == 0))
                     ? int'(bcdca_pkg::DAYS_LEAP) : int'(bcdca_pkg::DAYS_FEB);
      else
         month_len = int'(bcdca_pkg::DAYS_LONG);
      if (day_num < month_len) begin
         enc = to_bcd(day_num + 1);
         nd.day = enc[5:0];
      end else begin
         nd.day = 6'h01;
         if (month_num < int'(bcdca_pkg::MONTHS_PER_YEAR)) begin
            enc = to_bcd(month_num + 1);
            nd.month = enc[4:0];
         end else begin
            nd.month = 5'h01;
            if (yy_num < int'(bcdca_pkg::YEAR_LAST))
               nd.year = {year[15:8], to_bcd(yy_num + 1)};
            else if (cen_num < int'(bcdca_pkg::YEAR_LAST))
               nd.year = {to_bcd(cen_num + 1), 8'h00};
            else
               nd.year = 16'h0000;
         end
      end
      return nd;
   endfunction

   task automatic queue_date(logic [5:0] day, logic [4:0] month, logic [15:0] year);
      date_req_type item;
      item.day           = day;
      item.month         = month;
      item.year          = year;
      item.send_idle_pct = phase_send_pct;
      item.recv_idle_pct = phase_recv_pct;
      item.wait_drained  = mark_wait_drained;
      item.hold_rsp      = mark_hold_rsp;
      pending_dates.push_back(item);
      mark_wait_drained = 1'b0;
      mark_hold_rsp     = 1'b0;
   endtask

   task automatic queue_random_date();
      int pick;
      int mon;
      int dom;
      int cen;
      int yy;
      pick = $urandom_range(99);
      if (pick < 20) begin
         queue_date(6'($urandom_range(63)), 5'($urandom_range(31)), 16'($urandom_range(65535)));
      end else begin
         mon = $urandom_range(1, 12);
         dom = (pick < 60) ? $urandom_range(26, 31) : $urandom_range(1, 31);
         cen = ($urandom_range(9) == 0) ? 99 : $urandom_range(99);
         yy  = ($urandom_range(4) == 0) ? 99 : $urandom_range(99);
         if (mon == 2 && $urandom_range(2) == 0)
            yy = 0;
         queue_date(6'(to_bcd(dom)), 5'(to_bcd(mon)), {to_bcd(cen), to_bcd(yy)});
      end
   endtask

   always @(posedge clock) begin : drive_req
      bit           launch;
      date_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_dates.push_back(following_date(req_tdata[5:0], req_tdata[10:6],
                                                    req_tdata[26:11]));
         if (!req_tvalid || req_tready) begin
            launch = 1'b0;
            if (pending_dates.size() > 0) begin
               item = pending_dates[0];
               if (!(item.wait_drained && expected_dates.size() > 0))
                  launch = ($urandom_range(99) >= item.send_idle_pct);
            end
            if (launch) begin
               void'(pending_dates.pop_front());
               req_tdata <= {5'b00000, item.year, item.month, item.day};
               recv_idle_pct = item.recv_idle_pct;
               if (item.hold_rsp)
                  hold_requests++;
            end
            req_tvalid <= launch;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      next_date_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("result with no date pending: rsp_tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_tdata[5:0] !== want.day) begin
                  $error("next_day_bcd: expected %h, got %h", want.day, rsp_tdata[5:0]);
                  mismatches++;
               end
               if (rsp_tdata[10:6] !== want.month) begin
                  $error("next_month_bcd: expected %h, got %h", want.month, rsp_tdata[10:6]);
                  mismatches++;
               end
               if (rsp_tdata[26:11] !== want.year) begin
                  $error("next_year_bcd: expected %h, got %h", want.year, rsp_tdata[26:11]);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : run_sequence
      phase_send_pct = 6;
      phase_recv_pct = 61;
      queue_date(6'h31, 5'h12, 16'h9999);
      queue_date(6'h31, 5'h12, 16'h1999);
      queue_date(6'h31, 5'h12, 16'h9899);
      queue_date(6'h31, 5'h12, 16'h0099);
      queue_date(6'h31, 5'h12, 16'h2024);
      queue_date(6'h31, 5'h01, 16'h2024);
      queue_date(6'h28, 5'h02, 16'h2023);
      queue_date(6'h28, 5'h02, 16'h2024);
      queue_date(6'h29, 5'h02, 16'h2024);
      queue_date(6'h28, 5'h02, 16'h1900);
      queue_date(6'h28, 5'h02, 16'h2000);
      queue_date(6'h30, 5'h02, 16'h2024);
      queue_date(6'h30, 5'h04, 16'h2024);
      queue_date(6'h30, 5'h06, 16'h1850);
      queue_date(6'h30, 5'h09, 16'h0000);
      queue_date(6'h30, 5'h11, 16'h4321);
      queue_date(6'h30, 5'h10, 16'h2024);
      queue_date(6'h00, 5'h05, 16'h2024);
      queue_date(6'h31, 5'h00, 16'h2024);
      queue_date(6'h31, 5'h1F, 16'h12AB);
      queue_date(6'h3F, 5'h0A, 16'hFFFF);
      queue_date(6'h0F, 5'h1F, 16'hFFFF);
      queue_date(6'h31, 5'h13, 16'hFFFF);
      queue_date(6'h2A, 5'h01, 16'h0000);
      queue_date(6'h01, 5'h01, 16'h0000);
      repeat (430) queue_random_date();

      phase_send_pct = 61;
      phase_recv_pct = 6;
      mark_wait_drained = 1'b1;
      repeat (430) queue_random_date();

      phase_send_pct = 0;
      phase_recv_pct = 0;
      mark_wait_drained = 1'b1;
      mark_hold_rsp = 1'b1;
      repeat (440) queue_random_date();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_dates.size() > 0 || req_tvalid || expected_dates.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("bcd_calendar_day_advance_top_test OK");
      else
         $display("bcd_calendar_day_advance_top_test NOT OK");
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("bcd_calendar_day_advance_top_test NOT OK");
      $finish;
   end

endmodule
